// ===== hdl/irht_pkg.sv =====
// Shared types, codes and arithmetic helpers for the image-map region hit tester.
`timescale 1ns / 1ps

package irht_pkg;

  // Geometry and sizing
  localparam int COORD_BITS  = 16;
  localparam int REGION_BITS = 10;
  localparam int KIND_BITS   = 4;
  localparam int CNT_BITS    = 7;
  localparam int MAX_VERTS   = 100;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int SQ_BITS     = PROD_BITS - 1;
  localparam int DIST_BITS   = PROD_BITS;
  localparam int CROSS_BITS  = PROD_BITS + 1;
  localparam int WIND_BITS   = 8;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(MAX_VERTS);

  // Region kinds
  localparam logic [KIND_BITS-1:0] KIND_DEFAULT = 4'd0;
  localparam logic [KIND_BITS-1:0] KIND_TEXT    = 4'd1;
  localparam logic [KIND_BITS-1:0] KIND_POINT   = 4'd2;
  localparam logic [KIND_BITS-1:0] KIND_RECT    = 4'd3;
  localparam logic [KIND_BITS-1:0] KIND_CIRCLE  = 4'd4;
  localparam logic [KIND_BITS-1:0] KIND_SPOLY   = 4'd5;
  localparam logic [KIND_BITS-1:0] KIND_POLY    = 4'd6;
  localparam logic [KIND_BITS-1:0] KIND_END     = 4'd8;

  // Outcomes
  localparam logic [1:0] OUT_NONE     = 2'd0;
  localparam logic [1:0] OUT_REDIRECT = 2'd1;
  localparam logic [1:0] OUT_ERROR    = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_TOO_MANY    = 3'd1;
  localparam logic [2:0] ERR_NO_POINT    = 3'd2;
  localparam logic [2:0] ERR_FEW_RECT    = 3'd3;
  localparam logic [2:0] ERR_FEW_CIRCLE  = 3'd4;
  localparam logic [2:0] ERR_FEW_SPOLY   = 3'd5;
  localparam logic [2:0] ERR_FEW_POLY    = 3'd6;
  localparam logic [2:0] ERR_UNKNOWN     = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TEST_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEST_Y = 1'b1;

  typedef struct packed {
    logic [KIND_BITS-1:0]          kind;
    logic [REGION_BITS-1:0]        region_index;
    logic signed [COORD_BITS-1:0]  vertex_x;
    logic signed [COORD_BITS-1:0]  vertex_y;
    logic                          vertex_valid;
    logic                          last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             outcome;
    logic [REGION_BITS-1:0] chosen_region;
    logic [2:0]             error_code;
  } out_item_t;

  // Pre-computed edge crossing terms, resolved after the products are registered
  typedef struct packed {
    logic                         straddle;
    logic                         down;
    logic                         same_x;
    logic                         right;
    logic signed [PROD_BITS-1:0]  prod_a;
    logic signed [PROD_BITS-1:0]  prod_b;
  } edge_t;

  // Line stage to decision stage
  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [REGION_BITS-1:0] region;
    logic                   last;
    logic [CNT_BITS-1:0]    n;
    edge_t                  e_open;
    edge_t                  e_close;
    logic                   rect_hit;
    logic [SQ_BITS-1:0]     sq_ctr_x;
    logic [SQ_BITS-1:0]     sq_ctr_y;
    logic [SQ_BITS-1:0]     sq_rim_x;
    logic [SQ_BITS-1:0]     sq_rim_y;
  } mid_t;

  function automatic logic signed [DIFF_BITS-1:0] coord_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return DIFF_BITS'(a) - DIFF_BITS'(b);
  endfunction

  function automatic logic [SQ_BITS-1:0] sq_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    logic signed [PROD_BITS-1:0] p;
    d = coord_diff(a, b);
    p = PROD_BITS'(d) * PROD_BITS'(d);
    return p[SQ_BITS-1:0];
  endfunction

  // Edge from p to q against the test point: flags and the two cross-product terms
  function automatic edge_t make_edge(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] qx,
    input logic signed [COORD_BITS-1:0] qy,
    input logic signed [COORD_BITS-1:0] tx,
    input logic signed [COORD_BITS-1:0] ty,
    input logic                         en
  );
    edge_t e;
    logic signed [DIFF_BITS-1:0] d_pt_x;
    logic signed [DIFF_BITS-1:0] d_qp_y;
    logic signed [DIFF_BITS-1:0] d_pt_y;
    logic signed [DIFF_BITS-1:0] d_qp_x;
    d_pt_x     = coord_diff(px, tx);
    d_qp_y     = coord_diff(qy, py);
    d_pt_y     = coord_diff(py, ty);
    d_qp_x     = coord_diff(qx, px);
    e.down     = (py >= ty);
    e.straddle = en && (e.down != (qy >= ty));
    e.right    = (px >= tx);
    e.same_x   = (e.right == (qx >= tx));
    e.prod_a   = PROD_BITS'(d_pt_x) * PROD_BITS'(d_qp_y);
    e.prod_b   = PROD_BITS'(d_pt_y) * PROD_BITS'(d_qp_x);
    return e;
  endfunction

  // Winding contribution of one edge: -1, 0 or +1
  function automatic logic signed [1:0] edge_step(input edge_t e);
    logic signed [CROSS_BITS-1:0] cr;
    logic take;
    cr = CROSS_BITS'($signed(e.prod_a)) - CROSS_BITS'($signed(e.prod_b));
    if (!e.straddle) begin
      take = 1'b0;
    end else if (e.same_x) begin
      take = e.right;
    end else if (e.down) begin
      take = cr[CROSS_BITS-1] || (cr == '0);
    end else begin
      take = !cr[CROSS_BITS-1];
    end
    if (!take) begin
      return 2'sd0;
    end else if (e.down) begin
      return -2'sd1;
    end else begin
      return 2'sd1;
    end
  endfunction

endpackage

// ===== hdl/imagemap_region_hit_test_core.sv =====
// Top level of the image-map region hit tester: ports, test point registers, input register.
//
// Usage: write the test point through the configuration channel (index 0 test_x,
// index 1 test_y, 16-bit two's complement) while the block is idle; cfg_ready_o is
// always high. Then stream the map on the input channel, one vertex item per transfer,
// each region line closed by an item with last_vertex set, and the map closed by an
// end-of-map item. Only the end-of-map item gives a result: outcome, chosen region and
// error code on the output channel.
// Throughput: one input item per clock cycle while in_ready_o is high. The path from the
// end-of-map transfer to the result is an input register, a line stage
// (vertex tracking and the edge and distance multipliers, registered) and a decision
// stage (winding sum and region tests) feeding the result register.
// A stalled receiver holds a later end-of-map item at the decision stage while a result
// waits; one more item enters the input register and then in_ready_o drops until the
// result is taken. Vertex items never wait on the receiver otherwise. Reset clears the
// test point to (0,0), the map state and all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module imagemap_region_hit_test_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [irht_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [irht_pkg::COORD_BITS-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  irht_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output irht_pkg::out_item_t                   out_data_o
);

  logic signed [irht_pkg::COORD_BITS-1:0] test_x_q, test_y_q;
  logic                                   in_valid_q;
  irht_pkg::in_item_t                     in_q;
  logic                                   line_ready;
  logic                                   mid_valid, mid_ready;
  irht_pkg::mid_t                         mid;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !in_valid_q || line_ready;

  // Test point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_x_q <= '0;
      test_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        irht_pkg::REG_TEST_X: test_x_q <= cfg_data_i;
        irht_pkg::REG_TEST_Y: test_y_q <= cfg_data_i;
        default: begin
          test_x_q <= test_x_q;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  irht_line_stage u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .test_x_i    (test_x_q),
    .test_y_i    (test_y_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (line_ready),
    .in_item_i   (in_q),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  irht_decide_stage u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .test_x_i    (test_x_q),
    .test_y_i    (test_y_q),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/irht_line_stage.sv =====
// Line stage: vertex tracking per region line, edge products and squared distances.
`timescale 1ns / 1ps

module irht_line_stage (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [irht_pkg::COORD_BITS-1:0] test_x_i,
  input  logic signed [irht_pkg::COORD_BITS-1:0] test_y_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  irht_pkg::in_item_t                     in_item_i,
  output logic                                   mid_valid_o,
  input  logic                                   mid_ready_i,
  output irht_pkg::mid_t                         mid_o
);

  logic [irht_pkg::CNT_BITS-1:0]          cnt_q, cnt_d;
  logic signed [irht_pkg::COORD_BITS-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [irht_pkg::COORD_BITS-1:0] second_x_q, second_x_d, second_y_q, second_y_d;
  logic signed [irht_pkg::COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                                   open_en;
  logic                                   fire;
  logic                                   line_done;
  logic                                   mid_valid_q;
  irht_pkg::mid_t                         mid_q, mid_d;

  assign in_ready_o  = !mid_valid_q || mid_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign line_done   = in_item_i.last_vertex || (in_item_i.kind == irht_pkg::KIND_END);
  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

  // Take the vertex into the line state
  always_comb begin
    cnt_d      = cnt_q;
    first_x_d  = first_x_q;
    first_y_d  = first_y_q;
    second_x_d = second_x_q;
    second_y_d = second_y_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    if (in_item_i.vertex_valid) begin
      if (cnt_q == '0) begin
        first_x_d = in_item_i.vertex_x;
        first_y_d = in_item_i.vertex_y;
      end else if (cnt_q == irht_pkg::CNT_BITS'(1)) begin
        second_x_d = in_item_i.vertex_x;
        second_y_d = in_item_i.vertex_y;
      end
      prev_x_d = in_item_i.vertex_x;
      prev_y_d = in_item_i.vertex_y;
      if (cnt_q != irht_pkg::CNT_MAX) begin
        cnt_d = cnt_q + irht_pkg::CNT_BITS'(1);
      end
    end
  end

  // Edge terms and distance squares for the decision stage
  assign open_en = in_item_i.vertex_valid && (cnt_q != '0) && (cnt_q < irht_pkg::CNT_LIMIT);

  always_comb begin
    mid_d.kind     = in_item_i.kind;
    mid_d.region   = in_item_i.region_index;
    mid_d.last     = in_item_i.last_vertex;
    mid_d.n        = cnt_d;
    mid_d.e_open   = irht_pkg::make_edge(prev_x_q, prev_y_q, in_item_i.vertex_x,
                                         in_item_i.vertex_y, test_x_i, test_y_i, open_en);
    mid_d.e_close  = irht_pkg::make_edge(prev_x_d, prev_y_d, first_x_d, first_y_d,
                                         test_x_i, test_y_i, 1'b1);
    mid_d.rect_hit = ((first_x_d >= test_x_i) != (second_x_d >= test_x_i)) &&
                     ((first_y_d >= test_y_i) != (second_y_d >= test_y_i));
    mid_d.sq_ctr_x = irht_pkg::sq_diff(first_x_d, test_x_i);
    mid_d.sq_ctr_y = irht_pkg::sq_diff(first_y_d, test_y_i);
    mid_d.sq_rim_x = irht_pkg::sq_diff(first_x_d, second_x_d);
    mid_d.sq_rim_y = irht_pkg::sq_diff(first_y_d, second_y_d);
  end

  // Vertex count; clear at the end of each line and at end of map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mid_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q <= line_done ? '0 : cnt_d;
      end
      if (in_ready_o) begin
        mid_valid_q <= in_valid_i;
      end
    end
  end

  // Coordinates are only read once the count says they were written
  always_ff @(posedge clk_i) begin
    if (fire) begin
      first_x_q  <= first_x_d;
      first_y_q  <= first_y_d;
      second_x_q <= second_x_d;
      second_y_q <= second_y_d;
      prev_x_q   <= prev_x_d;
      prev_y_q   <= prev_y_d;
      mid_q      <= mid_d;
    end
  end

endmodule

// ===== hdl/irht_decide_stage.sv =====
// Decision stage: winding sum, region tests, first-hit tracking and the result register.
`timescale 1ns / 1ps

module irht_decide_stage (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [irht_pkg::COORD_BITS-1:0] test_x_i,
  input  logic signed [irht_pkg::COORD_BITS-1:0] test_y_i,
  input  logic                                   mid_valid_i,
  output logic                                   mid_ready_o,
  input  irht_pkg::mid_t                         mid_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output irht_pkg::out_item_t                    out_data_o
);

  logic                                   decided_q, decided_d;
  logic [irht_pkg::REGION_BITS-1:0]       hit_region_q, hit_region_d;
  logic [2:0]                             err_code_q, err_code_d;
  logic                                   fb_valid_q, fb_valid_d;
  logic [irht_pkg::REGION_BITS-1:0]       fb_region_q, fb_region_d;
  logic                                   saw_point_q, saw_point_d;
  logic [irht_pkg::DIST_BITS-1:0]         min_dist_q, min_dist_d;
  logic signed [irht_pkg::WIND_BITS-1:0]  wind_q, wind_d;
  logic                                   out_valid_q, out_valid_d;
  irht_pkg::out_item_t                    out_q, result;

  logic signed [1:0]                      c_open, c_close;
  logic signed [irht_pkg::WIND_BITS-1:0]  wind_run, wind_fin;
  logic [irht_pkg::DIST_BITS-1:0]         dist_ctr, dist_rim;
  logic [2:0]                             err;
  logic                                   hit, fb_set, pt_set;
  logic                                   is_end, out_free, fire;

  assign is_end      = (mid_i.kind == irht_pkg::KIND_END);
  assign out_free    = !out_valid_q || out_ready_i;
  assign mid_ready_o = !is_end || out_free;
  assign fire        = mid_valid_i && mid_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Line tests
  always_comb begin
    c_open   = irht_pkg::edge_step(mid_i.e_open);
    c_close  = irht_pkg::edge_step(mid_i.e_close);
    wind_run = wind_q + irht_pkg::WIND_BITS'(c_open);
    wind_fin = wind_run + irht_pkg::WIND_BITS'(c_close);
    dist_ctr = irht_pkg::DIST_BITS'(mid_i.sq_ctr_x) + irht_pkg::DIST_BITS'(mid_i.sq_ctr_y);
    dist_rim = irht_pkg::DIST_BITS'(mid_i.sq_rim_x) + irht_pkg::DIST_BITS'(mid_i.sq_rim_y);
    err      = irht_pkg::ERR_NONE;
    hit      = 1'b0;
    fb_set   = 1'b0;
    pt_set   = 1'b0;
    if (mid_i.n >= irht_pkg::CNT_LIMIT) begin
      err = irht_pkg::ERR_TOO_MANY;
    end else begin
      case (mid_i.kind)
        irht_pkg::KIND_DEFAULT: begin
          fb_set = 1'b1;
        end
        irht_pkg::KIND_TEXT: begin
          hit = (test_x_i == '0) && (test_y_i == '0);
        end
        irht_pkg::KIND_POINT: begin
          if (mid_i.n == '0) begin
            err = irht_pkg::ERR_NO_POINT;
          end else if (!saw_point_q || (dist_ctr < min_dist_q)) begin
            pt_set = 1'b1;
          end
        end
        irht_pkg::KIND_RECT: begin
          if (mid_i.n < irht_pkg::CNT_BITS'(2)) begin
            err = irht_pkg::ERR_FEW_RECT;
          end else begin
            hit = mid_i.rect_hit;
          end
        end
        irht_pkg::KIND_CIRCLE: begin
          if (mid_i.n < irht_pkg::CNT_BITS'(2)) begin
            err = irht_pkg::ERR_FEW_CIRCLE;
          end else begin
            hit = (dist_ctr <= dist_rim);
          end
        end
        irht_pkg::KIND_SPOLY: begin
          if (mid_i.n < irht_pkg::CNT_BITS'(3)) begin
            err = irht_pkg::ERR_FEW_SPOLY;
          end else begin
            hit = (wind_fin != '0);
          end
        end
        irht_pkg::KIND_POLY: begin
          if (mid_i.n < irht_pkg::CNT_BITS'(3)) begin
            err = irht_pkg::ERR_FEW_POLY;
          end else begin
            hit = wind_fin[0];
          end
        end
        default: begin
          err = irht_pkg::ERR_UNKNOWN;
        end
      endcase
    end
  end

  // End-of-map result from the map state
  always_comb begin
    result.outcome       = irht_pkg::OUT_NONE;
    result.chosen_region = '0;
    result.error_code    = irht_pkg::ERR_NONE;
    if (decided_q) begin
      result.outcome       = (err_code_q != irht_pkg::ERR_NONE) ? irht_pkg::OUT_ERROR
                                                                : irht_pkg::OUT_REDIRECT;
      result.chosen_region = hit_region_q;
      result.error_code    = err_code_q;
    end else if (fb_valid_q) begin
      result.outcome       = irht_pkg::OUT_REDIRECT;
      result.chosen_region = fb_region_q;
    end
  end

  // Map state update; items after a decision are dropped until end of map
  always_comb begin
    decided_d    = decided_q;
    hit_region_d = hit_region_q;
    err_code_d   = err_code_q;
    fb_valid_d   = fb_valid_q;
    fb_region_d  = fb_region_q;
    saw_point_d  = saw_point_q;
    min_dist_d   = min_dist_q;
    wind_d       = wind_q;
    if (fire) begin
      if (is_end) begin
        decided_d    = 1'b0;
        hit_region_d = '0;
        err_code_d   = irht_pkg::ERR_NONE;
        fb_valid_d   = 1'b0;
        fb_region_d  = '0;
        saw_point_d  = 1'b0;
        min_dist_d   = '0;
        wind_d       = '0;
      end else if (!decided_q) begin
        wind_d = mid_i.last ? '0 : wind_run;
        if (mid_i.last) begin
          if (fb_set || pt_set) begin
            fb_valid_d  = 1'b1;
            fb_region_d = mid_i.region;
          end
          if (pt_set) begin
            saw_point_d = 1'b1;
            min_dist_d  = dist_ctr;
          end
          if ((err != irht_pkg::ERR_NONE) || hit) begin
            decided_d    = 1'b1;
            err_code_d   = err;
            hit_region_d = mid_i.region;
          end
        end
      end
    end
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && is_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q    <= 1'b0;
      hit_region_q <= '0;
      err_code_q   <= irht_pkg::ERR_NONE;
      fb_valid_q   <= 1'b0;
      fb_region_q  <= '0;
      saw_point_q  <= 1'b0;
      min_dist_q   <= '0;
      wind_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      decided_q    <= decided_d;
      hit_region_q <= hit_region_d;
      err_code_q   <= err_code_d;
      fb_valid_q   <= fb_valid_d;
      fb_region_q  <= fb_region_d;
      saw_point_q  <= saw_point_d;
      min_dist_q   <= min_dist_d;
      wind_q       <= wind_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_end) begin
      out_q <= result;
    end
  end

endmodule
